@@ rtl/hwt_pkg.sv @@
// Package for the hashed timer wheel: sizes, field types, command and status
// codes, and the command/status structs between controller and datapath.
// Depends on nothing; every other file in rtl/ uses it.
package hwt_pkg;

    // Wheel geometry and table size
    localparam int SLOT_COUNT    = 64;
    localparam int TICK_INTERVAL = 1;
    localparam int MAX_TIMERS    = 32;
    localparam int RES_LIMIT     = 32;

    // Fixed field widths of the ports
    localparam int CMD_W    = 2;
    localparam int DELAY_W  = 24;
    localparam int HANDLE_W = 5;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 3;

    // Derived widths
    localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int ROT_MAX = ((1 << DELAY_W) - 1) / (SLOT_COUNT * TICK_INTERVAL);
    localparam int ROT_W  = (ROT_MAX > 0) ? $clog2(ROT_MAX + 1) : 1;
    localparam int CNT_W  = $clog2(RES_LIMIT + 1);

    typedef logic [CMD_W-1:0]    cmd_code_t;
    typedef logic [DELAY_W-1:0]  delay_t;
    typedef logic [HANDLE_W-1:0] handle_t;
    typedef logic [TAG_W-1:0]    tag_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [SLOT_W:0]     slot_sum_t;
    typedef logic [ROT_W-1:0]    rot_t;
    typedef logic [CNT_W-1:0]    cnt_t;

    // Command codes
    localparam cmd_code_t CMD_ADD    = 2'd0;
    localparam cmd_code_t CMD_REMOVE = 2'd1;
    localparam cmd_code_t CMD_TICK   = 2'd2;

    // Result status codes
    localparam status_t ST_ADDED    = 3'd0;
    localparam status_t ST_FULL     = 3'd1;
    localparam status_t ST_REMOVED  = 3'd2;
    localparam status_t ST_NOTFOUND = 3'd3;
    localparam status_t ST_EXPIRED  = 3'd4;
    localparam status_t ST_IDLE     = 3'd5;

    // One timer entry as held in the table memory
    typedef struct packed {
        slot_t slot;
        rot_t  rot;
        tag_t  tag;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic cap;        // capture the input fields
        logic rd_handle;  // read table at the captured handle
        logic rd_scan;    // read table at the next scan index
        logic scan_clr;   // restart the scan at entry zero
        logic scan_inc;   // step the scan index
        logic do_add;     // place a new timer, report added or full
        logic do_remove;  // free the captured handle, report the outcome
        logic do_eval;    // decrement or expire the scanned entry
        logic do_finish;  // give the final tick result, advance the wheel
    } hwt_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic eval_stall;  // scanned entry needs the output and it is busy
        logic scan_last;   // scan index is at the last entry
    } hwt_stat_t;

endpackage

@@ rtl/hwt_datapath.sv @@
// Datapath of the hashed timer wheel: table memory, valid bits, wheel
// position, tick scan state and the result output register.
// Depends on hwt_pkg; driven by hwt_ctrl through hwt_pkg::hwt_cmd_t.
module hwt_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  hwt_pkg::delay_t     delay,
    input  hwt_pkg::handle_t    handle,
    input  hwt_pkg::tag_t       owner_tag,
    input  hwt_pkg::hwt_cmd_t   cmd,
    output hwt_pkg::hwt_stat_t  stat,
    output logic                out_valid,
    input  logic                out_ready,
    output hwt_pkg::status_t    status,
    output hwt_pkg::handle_t    handle_res,
    output hwt_pkg::tag_t       owner_tag_res,
    output logic                last
);

    // Captured input fields
    hwt_pkg::delay_t  delay_reg;
    hwt_pkg::handle_t handle_reg;
    hwt_pkg::tag_t    tag_reg;

    // Table storage
    hwt_pkg::entry_t               mem [hwt_pkg::MAX_TIMERS];
    hwt_pkg::entry_t               rdata_reg;
    logic [hwt_pkg::MAX_TIMERS-1:0] valid_reg, valid_next;

    // Wheel and scan state
    hwt_pkg::slot_t cur_slot_reg, cur_slot_next;
    hwt_pkg::idx_t  scan_reg, scan_next;
    hwt_pkg::cnt_t  cnt_reg, cnt_next;

    // Expiry held back until it is known whether another follows
    logic           pend_valid_reg, pend_valid_next;
    hwt_pkg::idx_t  pend_idx_reg;
    hwt_pkg::tag_t  pend_tag_reg;

    // Output register
    logic             out_valid_reg, out_valid_next;
    hwt_pkg::status_t out_status_reg;
    hwt_pkg::handle_t out_handle_reg;
    hwt_pkg::tag_t    out_tag_reg;
    logic             out_last_reg;

    // Combinational helpers
    logic             free_found;
    hwt_pkg::idx_t    free_idx;
    hwt_pkg::delay_t  ticks;
    hwt_pkg::slot_t   slot_off;
    hwt_pkg::slot_sum_t slot_sum;
    hwt_pkg::slot_t   new_slot;
    hwt_pkg::rot_t    new_rot;
    hwt_pkg::idx_t    rm_idx;
    logic             rm_hit;
    logic             ev_match;
    logic             ev_zero;
    logic             ev_expire;
    logic             ev_dec;
    logic             out_free;
    logic             wr_en;
    hwt_pkg::idx_t    wr_addr;
    hwt_pkg::entry_t  wr_data;
    logic             rd_en;
    hwt_pkg::idx_t    rd_addr;
    logic             out_load;
    hwt_pkg::status_t ld_status;
    hwt_pkg::handle_t ld_handle;
    hwt_pkg::tag_t    ld_tag;
    logic             ld_last;

    // Find the lowest free handle
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = hwt_pkg::MAX_TIMERS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = hwt_pkg::idx_t'(i);
            end
        end
    end

    // Work out slot and rotation of a new timer
    always_comb
    begin
        ticks    = hwt_pkg::delay_t'(delay_reg / hwt_pkg::TICK_INTERVAL);
        slot_off = hwt_pkg::slot_t'(ticks % hwt_pkg::SLOT_COUNT);
        slot_sum = {1'b0, cur_slot_reg} + {1'b0, slot_off};
        if (slot_sum >= hwt_pkg::slot_sum_t'(hwt_pkg::SLOT_COUNT))
        begin
            new_slot = hwt_pkg::slot_t'(slot_sum - hwt_pkg::slot_sum_t'(hwt_pkg::SLOT_COUNT));
        end
        else
        begin
            new_slot = hwt_pkg::slot_t'(slot_sum);
        end
        new_rot = hwt_pkg::rot_t'(ticks / hwt_pkg::SLOT_COUNT);
    end

    // Qualify the remove handle and the scanned entry
    always_comb
    begin
        rm_idx    = hwt_pkg::idx_t'(handle_reg);
        rm_hit    = (int'(handle_reg) < hwt_pkg::MAX_TIMERS) && valid_reg[rm_idx];
        ev_match  = valid_reg[scan_reg] && (rdata_reg.slot == cur_slot_reg);
        ev_zero   = (rdata_reg.rot == '0);
        ev_expire = ev_match && ev_zero
                    && (cnt_reg < hwt_pkg::cnt_t'(hwt_pkg::RES_LIMIT));
        ev_dec    = ev_match && !ev_zero;
        out_free  = !out_valid_reg || out_ready;
    end

    // Status back to the controller
    always_comb
    begin
        stat.out_free   = out_free;
        stat.eval_stall = ev_expire && pend_valid_reg && !out_free;
        stat.scan_last  = (scan_reg == hwt_pkg::idx_t'(hwt_pkg::MAX_TIMERS - 1));
    end

    // Scan index, table write and read port
    always_comb
    begin
        if (cmd.scan_clr)
        begin
            scan_next = '0;
        end
        else if (cmd.scan_inc)
        begin
            scan_next = scan_reg + hwt_pkg::idx_t'(1);
        end
        else
        begin
            scan_next = scan_reg;
        end

        wr_en   = 1'b0;
        wr_addr = scan_reg;
        wr_data = '{slot: rdata_reg.slot, rot: rdata_reg.rot - hwt_pkg::rot_t'(1),
                    tag: rdata_reg.tag};
        if (cmd.do_add && free_found)
        begin
            wr_en   = 1'b1;
            wr_addr = free_idx;
            wr_data = '{slot: new_slot, rot: new_rot, tag: tag_reg};
        end
        else if (cmd.do_eval && ev_dec)
        begin
            wr_en = 1'b1;
        end

        rd_en   = cmd.rd_handle || cmd.rd_scan;
        rd_addr = cmd.rd_handle ? rm_idx : scan_next;
    end

    // Valid bits, wheel position, expiry count and held expiry
    always_comb
    begin
        valid_next      = valid_reg;
        cur_slot_next   = cur_slot_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;

        if (cmd.do_add && free_found)
        begin
            valid_next[free_idx] = 1'b1;
        end
        if (cmd.do_remove && rm_hit)
        begin
            valid_next[rm_idx] = 1'b0;
        end
        if (cmd.do_eval && ev_expire)
        begin
            valid_next[scan_reg] = 1'b0;
            cnt_next             = cnt_reg + hwt_pkg::cnt_t'(1);
            pend_valid_next      = 1'b1;
        end
        if (cmd.do_finish)
        begin
            cnt_next        = '0;
            pend_valid_next = 1'b0;
            if (cur_slot_reg == hwt_pkg::slot_t'(hwt_pkg::SLOT_COUNT - 1))
            begin
                cur_slot_next = '0;
            end
            else
            begin
                cur_slot_next = cur_slot_reg + hwt_pkg::slot_t'(1);
            end
        end
    end

    // Select the result to load into the output register
    always_comb
    begin
        out_load  = 1'b0;
        ld_status = hwt_pkg::ST_IDLE;
        ld_handle = '0;
        ld_tag    = '0;
        ld_last   = 1'b1;

        if (cmd.do_add)
        begin
            out_load = 1'b1;
            if (free_found)
            begin
                ld_status = hwt_pkg::ST_ADDED;
                ld_handle = hwt_pkg::handle_t'(free_idx);
            end
            else
            begin
                ld_status = hwt_pkg::ST_FULL;
            end
        end
        else if (cmd.do_remove)
        begin
            out_load = 1'b1;
            if (rm_hit)
            begin
                ld_status = hwt_pkg::ST_REMOVED;
                ld_handle = handle_reg;
                ld_tag    = rdata_reg.tag;
            end
            else
            begin
                ld_status = hwt_pkg::ST_NOTFOUND;
            end
        end
        else if (cmd.do_eval && ev_expire && pend_valid_reg)
        begin
            // A later expiry exists, so the held one is not the last
            out_load  = 1'b1;
            ld_status = hwt_pkg::ST_EXPIRED;
            ld_handle = hwt_pkg::handle_t'(pend_idx_reg);
            ld_tag    = pend_tag_reg;
            ld_last   = 1'b0;
        end
        else if (cmd.do_finish)
        begin
            out_load = 1'b1;
            if (pend_valid_reg)
            begin
                ld_status = hwt_pkg::ST_EXPIRED;
                ld_handle = hwt_pkg::handle_t'(pend_idx_reg);
                ld_tag    = pend_tag_reg;
            end
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            cur_slot_reg   <= '0;
            scan_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            cur_slot_reg   <= cur_slot_next;
            scan_reg       <= scan_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payload: captured fields, held expiry and output result
    always_ff @(posedge clk)
    begin
        if (cmd.cap)
        begin
            delay_reg  <= delay;
            handle_reg <= handle;
            tag_reg    <= owner_tag;
        end
        if (cmd.do_eval && ev_expire)
        begin
            pend_idx_reg <= scan_reg;
            pend_tag_reg <= rdata_reg.tag;
        end
        if (out_load)
        begin
            out_status_reg <= ld_status;
            out_handle_reg <= ld_handle;
            out_tag_reg    <= ld_tag;
            out_last_reg   <= ld_last;
        end
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign handle_res    = out_handle_reg;
    assign owner_tag_res = out_tag_reg;
    assign last          = out_last_reg;

endmodule

@@ rtl/hwt_ctrl.sv @@
// Controller of the hashed timer wheel: sequences add, remove and the tick
// scan, and drives the datapath through hwt_pkg::hwt_cmd_t.
// Depends on hwt_pkg; status comes back from hwt_datapath.
module hwt_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  hwt_pkg::cmd_code_t  command,
    input  hwt_pkg::hwt_stat_t  stat,
    output logic                in_ready,
    output hwt_pkg::hwt_cmd_t   cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_RM_RD,
        S_RM,
        S_TK_RD,
        S_TK_EV,
        S_TK_END
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg;

    // Next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.cap = 1'b1;
                    case (command)
                        hwt_pkg::CMD_ADD:
                        begin
                            state_next = S_ADD;
                        end
                        hwt_pkg::CMD_REMOVE:
                        begin
                            state_next = S_RM_RD;
                        end
                        hwt_pkg::CMD_TICK:
                        begin
                            cmd.scan_clr = 1'b1;
                            state_next   = S_TK_RD;
                        end
                        default:
                        begin
                            // Unused code: drop the transfer
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                if (stat.out_free)
                begin
                    cmd.do_add = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RM_RD:
            begin
                cmd.rd_handle = 1'b1;
                state_next    = S_RM;
            end
            S_RM:
            begin
                if (stat.out_free)
                begin
                    cmd.do_remove = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_TK_RD:
            begin
                cmd.rd_scan = 1'b1;
                state_next  = S_TK_EV;
            end
            S_TK_EV:
            begin
                // Evaluate one entry a cycle unless stalled, reading the next one alongside
                if (!stat.eval_stall)
                begin
                    cmd.do_eval = 1'b1;
                    if (stat.scan_last)
                    begin
                        state_next = S_TK_END;
                    end
                    else
                    begin
                        cmd.scan_inc = 1'b1;
                        cmd.rd_scan  = 1'b1;
                    end
                end
            end
            S_TK_END:
            begin
                if (stat.out_free)
                begin
                    cmd.do_finish = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

endmodule

@@ rtl/hashed_timer_wheel_unit.sv @@
// Hashed timer wheel, 32 timers over 64 slots. Add: transfer captured, then the
// result is placed and registered; remove: one table read before the result.
// Tick: one table entry per cycle through the single read port while the output
// does not stall; the result stream ends with last set. One item at a time.
// Reset (rst_n, asynchronous) empties the table and sets the wheel to slot 0
// at once; entry contents are undefined until written, no clearing pass.
module hashed_timer_wheel_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  hwt_pkg::cmd_code_t command,
    input  hwt_pkg::delay_t    delay,
    input  hwt_pkg::handle_t   handle,
    input  hwt_pkg::tag_t      owner_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output hwt_pkg::status_t   status,
    output hwt_pkg::handle_t   handle_res,
    output hwt_pkg::tag_t      owner_tag_res,
    output logic               last
);

    hwt_pkg::hwt_cmd_t  cmd;
    hwt_pkg::hwt_stat_t stat;

    // Sequence the commands
    hwt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .stat     (stat),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Table, wheel and output
    hwt_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .delay         (delay),
        .handle        (handle),
        .owner_tag     (owner_tag),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .handle_res    (handle_res),
        .owner_tag_res (owner_tag_res),
        .last          (last)
    );

    // A final result never overwrites one that has not been taken
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.do_add || cmd.do_remove || cmd.do_finish) |-> stat.out_free)
        else $error("result loaded while output register busy");

    // The final tick result is presented on the next cycle
    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_finish |=> out_valid)
        else $error("tick finish did not present a result");

    // At most one table operation per cycle
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.cap, cmd.do_add, cmd.do_remove, cmd.do_eval, cmd.do_finish}))
        else $error("more than one table operation in a cycle");

    // A valid command keeps the block busy after its transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == hwt_pkg::CMD_ADD
            || command == hwt_pkg::CMD_REMOVE || command == hwt_pkg::CMD_TICK))
        |=> !in_ready)
        else $error("input ready while a command is in progress");

endmodule
